FILE: src/bida_pkg.sv
// shared types, codes and constants of the bounded insert/delete array
package bida_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CNT_W     = 5;
  localparam int WORD_W    = 32;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_WRITE  = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef struct packed {
    logic [2:0]              command;
    logic [CNT_W-1:0]        position;
    logic signed [WORD_W-1:0] word_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_word;
    logic [1:0]              status;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_full;
    logic                    is_empty;
  } out_item_t;

  // what every cell of the row does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_WRITE  = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [CNT_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

FILE: src/bounded_insert_delete_array.sv
// top level of the bounded insert/delete array list
//
// usage
//   in channel  : in_valid / in_stall / in_item, one operation per item
//                 (append, insert, read, overwrite, delete)
//   out channel : out_valid / out_stall / out_item, exactly one result per item
//                 carrying read data, status, entry count and full/empty flags
//   cfg channel : cfg_valid / cfg_ready / cfg_capacity_in_use, always ready,
//                 sets how many entries the list may hold; write only when idle
// latency     : a result shows on out_item one cycle after its item is taken
// throughput  : one item per cycle; the row of cells shifts every entry in the
//               same cycle, so insert and delete cost no more than a read
// stall       : while a result waits under out_stall, in_stall is raised and
//               the stored list and count hold
// reset       : rst_n (synchronous, active low) empties the list and sets the
//               capacity to 16; cell contents are left as they are
module bounded_insert_delete_array import bida_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_capacity_in_use
);

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] eff_cap;
  logic             full_now;
  logic             in_acc;
  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        res;
  cell_op_t         op;
  logic [CNT_W-1:0] op_pos;
  cell_ctl_t        ctl;
  logic [WORD_W-1:0] row_rd;

  // the output register parts the two sides: take an item unless a result waits
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // capacity register clamped to one .. depth
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_r) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = cap_r;
    end
  end

  assign full_now = (count_r >= eff_cap);

  // decode the operation, check its index, pick the cell action
  always_comb begin
    op         = CELL_HOLD;
    op_pos     = in_item.position;
    count_nxt  = count_r;
    res        = '0;
    res.status = ST_OK;
    case (in_item.command)
      CMD_APPEND: begin
        if (full_now) begin
          res.status = ST_OVERFLOW;
        end else begin
          op        = CELL_INSERT;
          op_pos    = count_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        // index before fullness
        if (in_item.position > count_r) begin
          res.status = ST_BAD_INDEX;
        end else if (full_now) begin
          res.status = ST_OVERFLOW;
        end else begin
          op        = CELL_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (in_item.position >= count_r) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.read_word = row_rd;
        end
      end
      CMD_WRITE: begin
        if (in_item.position >= count_r) begin
          res.status = ST_BAD_INDEX;
        end else begin
          op = CELL_WRITE;
        end
      end
      CMD_DELETE: begin
        if (in_item.position >= count_r) begin
          res.status = ST_BAD_INDEX;
        end else begin
          op        = CELL_DELETE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        // unused codes leave everything alone
        op = CELL_HOLD;
      end
    endcase
    res.entry_count = count_nxt;
    res.is_full     = (count_nxt >= eff_cap);
    res.is_empty    = (count_nxt == '0);
  end

  // the row only moves on an accepted item
  always_comb begin
    ctl.op   = in_acc ? op : CELL_HOLD;
    ctl.pos  = op_pos;
    ctl.word = in_item.word_in;
  end

  bida_row #(.DEPTH(DEPTH)) u_row (
    .clk     (clk),
    .ctl     (ctl),
    .rd_pos  (in_item.position),
    .rd_word (row_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_in_use;
      end
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_item_r <= res;
    end
  end

`ifndef SYNTH
  a_count_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("entry count beyond depth");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (res.status != ST_OK) |=> count_r == $past(count_r))
    else $error("count changed on a failed operation");

  a_overflow_is_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status == ST_OVERFLOW) |-> out_item_r.is_full)
    else $error("overflow reported while not full");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.is_empty == (out_item_r.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_item_r.entry_count == count_r)
    else $error("result count differs from stored count");
`endif

endmodule

FILE: src/bida_cell.sv
// one storage cell of the row, shifts with its neighbours
module bida_cell import bida_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  output logic [WORD_W-1:0] word_r
);

  logic [WORD_W-1:0] word_nxt;
  logic              at_pos;
  logic              above_pos;

  assign at_pos    = (32'(ctl.pos) == 32'(IDX));
  assign above_pos = (32'(IDX) > 32'(ctl.pos));

  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (above_pos) begin
          word_nxt = left_word;
        end else if (at_pos) begin
          word_nxt = ctl.word;
        end
      end
      CELL_WRITE: begin
        if (at_pos) begin
          word_nxt = ctl.word;
        end
      end
      CELL_DELETE: begin
        if (above_pos || at_pos) begin
          word_nxt = right_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

FILE: src/bida_row.sv
// row of cells holding the list, with the read select
module bida_row import bida_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]  rd_pos,
  output logic [WORD_W-1:0] rd_word
);

  logic [WORD_W-1:0] cell_q [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = ctl.word;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_q[g];
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end

    bida_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_word  (left_w),
      .right_word (right_w),
      .word_r     (cell_q[g])
    );
  end

  // one-hot select of the addressed cell
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(rd_pos) == 32'(i)) begin
        rd_word = cell_q[i];
      end
    end
  end

endmodule
